// File: design/ssir_pkg.sv
package ssir_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic load_in;
        logic compare;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/ssir_if.sv
interface ssir_in_if import ssir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ssir_out_if import ssir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [STATUS_W-1:0]           status;
    logic [COUNT_W-1:0]            entry_count;
    logic signed [VALUE_WIDTH-1:0] smallest;
    logic signed [VALUE_WIDTH-1:0] largest;

    modport source (output valid, output status, output entry_count, output smallest,
                    output largest, input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    input largest, output ready);
endinterface

// File: design/ssir_ctrl.sv
module ssir_ctrl import ssir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_RES
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.compare  = (r_state == S_CMP);
        o_cmd.update   = (r_state == S_UPD);
        o_cmd.load_out = (r_state == S_RES) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: design/ssir_dp.sv
module ssir_dp import ssir_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    ssir_in_if.sink           i_in,
    ssir_out_if.source        o_out
);

    logic                          r_mode;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic signed [VALUE_WIDTH-1:0] r_entries [CAPACITY];
    logic [CNT_W-1:0]              r_count;
    logic [CAPACITY-1:0]           r_lt;
    logic                          r_eq_any;
    t_status                       r_status;

    logic                          r_out_valid;
    t_status                       r_out_status;
    logic [COUNT_W-1:0]            r_out_count;
    logic signed [VALUE_WIDTH-1:0] r_out_small;
    logic signed [VALUE_WIDTH-1:0] r_out_large;

    logic [CAPACITY-1:0] n_lt;
    logic [CAPACITY-1:0] n_eq;
    logic                ins_ok;
    logic                rem_ok;
    logic [CNT_W-1:0]    last_cnt;
    logic [IDX_W-1:0]    last_idx;

    logic signed [VALUE_WIDTH-1:0] below_val [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] above_val [CAPACITY];
    logic [CAPACITY-1:0]           below_lt;

    // per-cell compare against the key, valid cells only
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i] = (CNT_W'(i) < r_count) && (r_entries[i] < r_key);
            n_eq[i] = (CNT_W'(i) < r_count) && (r_entries[i] == r_key);
        end
    end

    // neighbor values for the shift, key enters below cell 0
    always_comb begin
        below_val[0] = r_key;
        below_lt[0]  = 1'b1;
        for (int i = 1; i < CAPACITY; i++) begin
            below_val[i] = r_entries[i-1];
            below_lt[i]  = r_lt[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            above_val[i] = r_entries[i+1];
        end
        above_val[CAPACITY-1] = r_entries[CAPACITY-1];
    end

    assign ins_ok   = (r_mode == MODE_INSERT) && !r_eq_any && (r_count < CNT_W'(CAPACITY));
    assign rem_ok   = (r_mode == MODE_REMOVE) && r_eq_any;
    assign last_cnt = r_count - CNT_W'(1);
    assign last_idx = last_cnt[IDX_W-1:0];

    assign o_stat.out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.value;
        end
        if (i_cmd.compare) begin
            r_lt     <= n_lt;
            r_eq_any <= |n_eq;
        end
        if (i_cmd.update) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!r_lt[i]) begin
                    if (ins_ok) begin
                        r_entries[i] <= below_lt[i] ? r_key : below_val[i];
                    end else if (rem_ok) begin
                        r_entries[i] <= above_val[i];
                    end
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            if (r_count == '0) begin
                r_out_small <= '0;
                r_out_large <= '0;
            end else begin
                r_out_small <= r_entries[0];
                r_out_large <= r_entries[last_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_status    <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                priority if (ins_ok) begin
                    r_count  <= r_count + CNT_W'(1);
                    r_status <= ST_DONE;
                end else if (rem_ok) begin
                    r_count  <= r_count - CNT_W'(1);
                    r_status <= ST_DONE;
                end else if (r_mode == MODE_REMOVE) begin
                    r_status <= ST_ABSENT;
                end else if (r_eq_any) begin
                    r_status <= ST_PRESENT;
                end else begin
                    r_status <= ST_FULL;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_count = r_out_count;
    assign o_out.smallest    = r_out_small;
    assign o_out.largest     = r_out_large;

endmodule

// File: design/sorted_set_insert_remove.sv
// Sorted set of up to 16 distinct signed 32-bit values. Each input transfer inserts
// (mode 0) or removes (mode 1) one value and yields one result transfer with a status
// (done, already present, not found, set full), the count after the item, and the
// smallest and largest stored values (0 when empty). From input transfer to result an
// item goes through these steps in order: it is captured, all 16 cells compare
// against the key at once, the cells shift to open or close the gap, and the output
// register is loaded. The next input is taken right after that, while the result
// still waits in the output register; a stalled output holds the following item in
// its last step until the register frees.
module sorted_set_insert_remove import ssir_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssir_in_if.sink    i_in,
    ssir_out_if.source o_out
);

    t_cmd     cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    ssir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssir_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
